### hw/rtl/uvst_pkg.sv
// uvst_pkg: request and result types, codes and controller/datapath links
// for the unique value set table; no dependencies
package uvst_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 8;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_SPARE  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       scan;
        logic       fetch;
        logic       append;
        logic       move;
        logic       finish;
        logic [1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic       scan_done;
        logic       found;
        logic       full;
        logic [1:0] req_type;
    } dp_stat_t;

endpackage

### hw/rtl/uvst_ram.sv
// uvst_ram: generic single write port, single read port ram with registered read
// no dependencies
module uvst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/uvst_datapath.sv
// uvst_datapath: entry ram, count, scan pointer, compare and result register
// depends on uvst_pkg and uvst_ram
module uvst_datapath
    import uvst_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     request,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output rsp_t     result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      scan_idx_reg;
    logic [AW-1:0]      chk_idx_reg;
    logic               chk_valid_reg;
    logic               found_reg;
    logic [AW-1:0]      pos_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [1:0]         req_type_reg;
    rsp_t               result_reg;

    logic               hit;
    logic               issue;
    logic [CW-1:0]      last_idx;
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [VALUE_W-1:0] ram_rdata;

    assign hit      = chk_valid_reg && (ram_rdata == value_reg);
    assign issue    = cmd.scan && (scan_idx_reg != count_reg);
    assign last_idx = count_reg - CW'(1);

    assign ram_re    = issue || cmd.fetch;
    assign ram_raddr = cmd.fetch ? last_idx[AW-1:0] : scan_idx_reg[AW-1:0];
    assign ram_we    = cmd.append || cmd.move;
    assign ram_waddr = cmd.append ? count_reg[AW-1:0] : pos_reg;
    assign ram_wdata = cmd.append ? value_reg : ram_rdata;

    uvst_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.move)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load)
            begin
                scan_idx_reg  <= '0;
                chk_valid_reg <= 1'b0;
                found_reg     <= 1'b0;
            end
            else if (cmd.scan)
            begin
                chk_valid_reg <= issue;
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg    <= request.value;
            req_type_reg <= request.req_type;
        end
        if (issue)
        begin
            chk_idx_reg <= scan_idx_reg[AW-1:0];
        end
        if (cmd.scan && hit)
        begin
            pos_reg <= chk_idx_reg;
        end
        if (cmd.finish)
        begin
            result_reg.status   <= cmd.status;
            result_reg.count    <= COUNT_W'(count_next);
            result_reg.is_empty <= (count_next == '0);
        end
    end

    assign stat.scan_done = found_reg || ((scan_idx_reg == count_reg) && !chk_valid_reg);
    assign stat.found     = found_reg;
    assign stat.full      = (count_reg == CW'(CAPACITY));
    assign stat.req_type  = req_type_reg;
    assign result         = result_reg;

endmodule

### hw/rtl/uvst_ctrl.sv
// uvst_ctrl: request sequencer that drives the datapath scan, move and append
// depends on uvst_pkg
module uvst_ctrl
    import uvst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_MOVE,
        S_APPEND
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    priority if (stat.req_type == REQ_INSERT)
                    begin
                        if (stat.found)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_DUP;
                        end
                        else if (stat.full)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_FULL;
                        end
                    end
                    else if (stat.req_type == REQ_REMOVE)
                    begin
                        if (!stat.found)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_MISSING;
                        end
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = stat.found ? ST_OK : ST_MISSING;
                    end

                    if (cmd.finish)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (stat.req_type == REQ_INSERT)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.move   = 1'b1;
                cmd.finish = 1'b1;
                cmd.status = ST_OK;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                cmd.finish = 1'b1;
                cmd.status = ST_OK;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

### hw/rtl/unique_value_set_table.sv
// unique_value_set_table: top level joining the sequencer and the datapath
// depends on uvst_pkg, uvst_ctrl, uvst_datapath
//
// A request is taken when start is high and busy is low. The table is searched one
// stored entry per cycle through the registered read port of the entry ram. A search
// stops at the first hit or after the last stored entry; an insert then appends the
// value, and a remove fetches the last entry and moves it into the freed slot.
// The result sits on result for the single cycle in which done is high and must be
// captured then; the receiver cannot hold it off. A new request may be given in that
// same cycle. No clearing pass is needed after reset.
module unique_value_set_table
    import uvst_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    uvst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    uvst_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule

### hw/rtl/uvst_checker.sv
// uvst_checker: port level assertions for unique_value_set_table and its bind
// depends on uvst_pkg
module uvst_checker
    import uvst_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t result
);

    // a taken request keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");

    // busy only drops with a result, and results only come when the block has gone idle
    a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.is_empty |-> result.count == '0)
        else $error("empty flag with nonzero count");

endmodule

bind unique_value_set_table uvst_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### tb/sv/tb_unique_value_set_table.sv
// tb_unique_value_set_table: self-checking testbench for the unique value set table
// directed and random insert/remove/query requests checked against a built-in set model
// depends on uvst_pkg and unique_value_set_table
`timescale 1ns / 100ps

module tb_unique_value_set_table;

    import uvst_pkg::*;

    localparam int CAPACITY       = 128;
    localparam int RESET_CYCLES   = 5;
    localparam int TARGET_ITEMS   = 1850;
    localparam int POOL_SIZE      = 160;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = CAPACITY + 10;
    localparam int MAX_REPORTS    = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t request = '0;
    logic done;
    rsp_t result;

    unique_value_set_table #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    always #1 clk = ~clk;

    req_t        req_backlog[$];
    rsp_t        predicted_rsp[$];
    logic [31:0] held_vals[CAPACITY];
    int          held_len = 0;
    logic [31:0] value_pool[POOL_SIZE];
    int          n_total = 0;
    int          n_dispatched = 0;
    int          n_accepted = 0;
    int          err_cnt = 0;
    int          stall_cycles = 0;
    int          idle_pct;
    bit          take;

    // set model: search, then append, swap-remove or report
    function automatic rsp_t apply_set_request(input req_t r);
        int   pos;
        bit   found;
        rsp_t rsp;
        pos = held_len;
        found = 1'b0;
        for (int i = 0; i < held_len; i++)
        begin
            if (!found && held_vals[i] == r.value)
            begin
                found = 1'b1;
                pos = i;
            end
        end
        case (r.req_type)
            REQ_INSERT:
            begin
                if (found)
                    rsp.status = ST_DUP;
                else if (held_len >= CAPACITY)
                    rsp.status = ST_FULL;
                else
                begin
                    held_vals[held_len] = r.value;
                    held_len++;
                    rsp.status = ST_OK;
                end
            end
            REQ_REMOVE:
            begin
                if (found)
                begin
                    held_vals[pos] = held_vals[held_len - 1];
                    held_len--;
                    rsp.status = ST_OK;
                end
                else
                    rsp.status = ST_MISSING;
            end
            default:
                rsp.status = found ? ST_OK : ST_MISSING;
        endcase
        rsp.count = held_len[COUNT_W-1:0];
        rsp.is_empty = (held_len == 0);
        return rsp;
    endfunction

    function automatic void push_item(input logic [1:0] kind, input logic [31:0] v);
        req_t r;
        r.req_type = kind;
        r.value = v;
        req_backlog.push_back(r);
    endfunction

    function automatic logic [1:0] random_kind();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return REQ_INSERT;
        else if (pick < 75)
            return REQ_REMOVE;
        else if (pick < 95)
            return REQ_QUERY;
        return REQ_SPARE;
    endfunction

    // random requests drawn mostly from a window of the pool
    function automatic void add_mixed(input int n);
        int base;
        int span;
        base = $urandom_range(0, POOL_SIZE - 48);
        span = $urandom_range(8, 47);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 85)
                push_item(random_kind(), value_pool[base + $urandom_range(0, span)]);
            else
                push_item(random_kind(), $urandom);
        end
    endfunction

    // insert the whole pool past capacity, poke it while full, then drain it
    function automatic void add_fill_drain();
        int order[POOL_SIZE];
        int j;
        int t;
        for (int i = 0; i < POOL_SIZE; i++)
            order[i] = i;
        for (int i = POOL_SIZE - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            push_item(REQ_INSERT, value_pool[order[i]]);
            if ($urandom_range(99) < 5)
                push_item(REQ_QUERY, $urandom);
        end
        for (int i = 0; i < 8; i++)
            push_item(REQ_INSERT, value_pool[$urandom_range(0, POOL_SIZE - 1)]);
        for (int i = 0; i < 4; i++)
            push_item(REQ_INSERT, $urandom);
        for (int i = 0; i < 12; i++)
            push_item($urandom_range(0, 1) ? REQ_QUERY : REQ_SPARE,
                      value_pool[$urandom_range(0, POOL_SIZE - 1)]);
        for (int i = 0; i < 8; i++)
            push_item(REQ_REMOVE, $urandom);
        for (int i = POOL_SIZE - 1; i >= 0; i--)
            push_item(REQ_REMOVE, value_pool[order[i]]);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            take = start && !busy;
            if (take)
            begin
                predicted_rsp.push_back(apply_set_request(request));
                n_accepted++;
            end
            if (take || !start)
            begin
                if (n_dispatched < n_total / 3)
                    idle_pct = 8;
                else if (n_dispatched < (2 * n_total) / 3)
                    idle_pct = 48;
                else
                    idle_pct = 0;
                if (req_backlog.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    request <= req_backlog.pop_front();
                    n_dispatched++;
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (predicted_rsp.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("unexpected result: status=%0d count=%0d is_empty=%0d",
                             result.status, result.count, result.is_empty);
            end
            else
            begin
                rsp_t want;
                want = predicted_rsp.pop_front();
                if (result.status !== want.status || result.count !== want.count ||
                    result.is_empty !== want.is_empty)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("mismatch: exp status=%0d count=%0d is_empty=%0d, %s%0d %0d %0d",
                                 want.status, want.count, want.is_empty,
                                 "got ", result.status, result.count, result.is_empty);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;

        push_item(REQ_QUERY,  32'h0000_0000);
        push_item(REQ_REMOVE, 32'h0000_0005);
        push_item(REQ_INSERT, 32'h8000_0000);
        push_item(REQ_INSERT, 32'h7fff_ffff);
        push_item(REQ_INSERT, 32'h0000_0000);
        push_item(REQ_INSERT, 32'hffff_ffff);
        push_item(REQ_INSERT, 32'h8000_0000);
        push_item(REQ_QUERY,  32'h7fff_ffff);
        push_item(REQ_QUERY,  32'h0000_0001);
        push_item(REQ_SPARE,  32'hffff_ffff);
        push_item(REQ_SPARE,  32'h0000_0002);
        push_item(REQ_REMOVE, 32'h8000_0000);
        push_item(REQ_QUERY,  32'hffff_ffff);
        push_item(REQ_QUERY,  32'h8000_0000);
        push_item(REQ_REMOVE, 32'h0000_3039);
        push_item(REQ_REMOVE, 32'h0000_0000);
        push_item(REQ_REMOVE, 32'hffff_ffff);
        push_item(REQ_REMOVE, 32'h7fff_ffff);
        push_item(REQ_QUERY,  32'h7fff_ffff);
        push_item(REQ_INSERT, 32'h5555_5555);
        push_item(REQ_INSERT, 32'haaaa_aaaa);
        push_item(REQ_QUERY,  32'h5555_5554);
        push_item(REQ_REMOVE, 32'haaaa_aaaa);
        push_item(REQ_REMOVE, 32'h5555_5555);

        add_mixed(300);
        add_fill_drain();
        add_mixed(350);
        add_fill_drain();
        if (req_backlog.size() < TARGET_ITEMS)
            add_mixed(TARGET_ITEMS - req_backlog.size());
        n_total = req_backlog.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_total || predicted_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/uvst_pkg.sv
hw/rtl/uvst_ram.sv
hw/rtl/uvst_datapath.sv
hw/rtl/uvst_ctrl.sv
hw/rtl/unique_value_set_table.sv
hw/rtl/uvst_checker.sv
tb/sv/tb_unique_value_set_table.sv
